>>> hw/rtl/dpf_pkg.sv
// dpf_pkg: shared constants, register indexes and types of the delimiter packet finder
// used by dpf_cell, dpf_judge and delimiter_packet_finder_top; depends on nothing
package dpf_pkg;

	// default sizes of the window and the position counter
	localparam int MAX_DELIM_DEF     = 8;
	localparam int POSITION_BITS_DEF = 32;

	// fixed field widths
	localparam int BYTE_BITS      = 8;
	localparam int PATTERN_BITS   = 64;
	localparam int LEN_BITS       = 4;
	localparam int OUT_BITS       = 32;
	localparam int CFG_INDEX_BITS = 3;

	// configuration register indexes
	localparam logic [CFG_INDEX_BITS-1:0] REG_START_PATTERN = 3'd0;
	localparam logic [CFG_INDEX_BITS-1:0] REG_START_LENGTH  = 3'd1;
	localparam logic [CFG_INDEX_BITS-1:0] REG_END_PATTERN   = 3'd2;
	localparam logic [CFG_INDEX_BITS-1:0] REG_END_LENGTH    = 3'd3;

	// running match flags handed along the row of cells
	typedef struct packed {
		logic start_hit;
		logic stop_hit;
	} dpf_hit_t;

endpackage

>>> hw/rtl/delimiter_packet_finder_top.sv
// delimiter_packet_finder_top: finds packets framed by start and end delimiters in a byte stream
// depends on dpf_pkg, dpf_cell and dpf_judge
//
//   port group    direction  flow control       contents
//   in_*          into       valid / ready      data_byte, one stream byte per request
//   out_*         out of     valid / ready      packet_begin, packet_length
//   cfg_*         into       write enable only  cfg_index, cfg_data
//
// one byte a cycle is taken while in_ready is high; the window cells shift on each request and
// the position is judged from the registered window once the output register can take a result,
// so out_valid is registered after the byte MAX_DELIM-1 bytes past the end delimiter's position
// reset clears the fill count, position and packet state; no clearing pass is needed
// while a result waits in the output register and a judgement is pending, in_ready
// is held low; otherwise the window keeps shifting
module delimiter_packet_finder_top #(
	parameter int MAX_DELIM     = dpf_pkg::MAX_DELIM_DEF,
	parameter int POSITION_BITS = dpf_pkg::POSITION_BITS_DEF
) (
	input  logic                               clk,
	input  logic                               arst_n,
	input  logic                               in_valid,
	output logic                               in_ready,
	input  logic [dpf_pkg::BYTE_BITS-1:0]      data_byte,
	output logic                               out_valid,
	input  logic                               out_ready,
	output logic [dpf_pkg::OUT_BITS-1:0]       packet_begin,
	output logic [dpf_pkg::OUT_BITS-1:0]       packet_length,
	input  logic                               cfg_wr_en,
	input  logic [dpf_pkg::CFG_INDEX_BITS-1:0] cfg_index,
	input  logic [dpf_pkg::PATTERN_BITS-1:0]   cfg_data
);

	localparam int FILL_BITS = $clog2(MAX_DELIM + 1);
	localparam logic [FILL_BITS-1:0] FILL_FULL = MAX_DELIM[FILL_BITS-1:0];

	logic [dpf_pkg::PATTERN_BITS-1:0] start_pattern_q;
	logic [dpf_pkg::PATTERN_BITS-1:0] end_pattern_q;
	logic [dpf_pkg::LEN_BITS-1:0]     start_length_q;
	logic [dpf_pkg::LEN_BITS-1:0]     end_length_q;
	logic [FILL_BITS-1:0]             fill_q;
	logic                             judge_s1;
	logic                             judge_fire;
	logic                             accept;

	logic [dpf_pkg::BYTE_BITS-1:0] win_byte [MAX_DELIM];
	dpf_pkg::dpf_hit_t             hit_chain [MAX_DELIM+1];

	assign in_ready = !judge_s1 || judge_fire;
	assign accept   = in_valid && in_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			start_pattern_q <= '0;
			end_pattern_q   <= '0;
			start_length_q  <= dpf_pkg::LEN_BITS'(1);
			end_length_q    <= dpf_pkg::LEN_BITS'(1);
		end else if (cfg_wr_en) begin
			case (cfg_index)
				dpf_pkg::REG_START_PATTERN: start_pattern_q <= cfg_data;
				dpf_pkg::REG_START_LENGTH:  start_length_q  <= cfg_data[dpf_pkg::LEN_BITS-1:0];
				dpf_pkg::REG_END_PATTERN:   end_pattern_q   <= cfg_data;
				dpf_pkg::REG_END_LENGTH:    end_length_q    <= cfg_data[dpf_pkg::LEN_BITS-1:0];
				default: ;
			endcase
		end
	end

	// nothing is judged until the window has filled once
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fill_q   <= '0;
			judge_s1 <= 1'b0;
		end else begin
			if (accept) begin
				if (fill_q != FILL_FULL) begin
					fill_q <= fill_q + FILL_BITS'(1);
				end
				judge_s1 <= (fill_q >= FILL_FULL - FILL_BITS'(1));
			end else if (judge_fire) begin
				judge_s1 <= 1'b0;
			end
		end
	end

	// newest byte enters at the top cell, oldest sits in cell 0
	assign hit_chain[MAX_DELIM] = '{start_hit: 1'b1, stop_hit: 1'b1};

	for (genvar k = 0; k < MAX_DELIM; k++) begin : g_cell
		logic [dpf_pkg::BYTE_BITS-1:0] byte_feed;

		if (k == MAX_DELIM - 1) begin : g_head
			assign byte_feed = data_byte;
		end else begin : g_body
			assign byte_feed = win_byte[k+1];
		end

		dpf_cell #(
			.IDX(k)
		) u_cell (
			.clk       (clk),
			.shift_en  (accept),
			.byte_in   (byte_feed),
			.byte_out  (win_byte[k]),
			.start_byte(start_pattern_q[k*dpf_pkg::BYTE_BITS +: dpf_pkg::BYTE_BITS]),
			.stop_byte (end_pattern_q[k*dpf_pkg::BYTE_BITS +: dpf_pkg::BYTE_BITS]),
			.start_len (start_length_q),
			.stop_len  (end_length_q),
			.hit_in    (hit_chain[k+1]),
			.hit_out   (hit_chain[k])
		);
	end

	dpf_judge #(
		.MAX_DELIM    (MAX_DELIM),
		.POSITION_BITS(POSITION_BITS)
	) u_judge (
		.clk          (clk),
		.arst_n       (arst_n),
		.judge_req    (judge_s1),
		.hits         (hit_chain[0]),
		.stop_len     (end_length_q),
		.judge_fire   (judge_fire),
		.out_valid    (out_valid),
		.out_ready    (out_ready),
		.packet_begin (packet_begin),
		.packet_length(packet_length)
	);

endmodule

>>> hw/rtl/dpf_cell.sv
// dpf_cell: one window byte of the delimiter packet finder and its two byte compares
// depends on dpf_pkg
module dpf_cell #(
	parameter int IDX = 0
) (
	input  logic                          clk,
	input  logic                          shift_en,
	input  logic [dpf_pkg::BYTE_BITS-1:0] byte_in,
	output logic [dpf_pkg::BYTE_BITS-1:0] byte_out,
	input  logic [dpf_pkg::BYTE_BITS-1:0] start_byte,
	input  logic [dpf_pkg::BYTE_BITS-1:0] stop_byte,
	input  logic [dpf_pkg::LEN_BITS-1:0]  start_len,
	input  logic [dpf_pkg::LEN_BITS-1:0]  stop_len,
	input  dpf_pkg::dpf_hit_t             hit_in,
	output dpf_pkg::dpf_hit_t             hit_out
);

	localparam logic [dpf_pkg::LEN_BITS-1:0] CELL_IDX = IDX[dpf_pkg::LEN_BITS-1:0];

	logic [dpf_pkg::BYTE_BITS-1:0] byte_q;
	logic                          start_ok;
	logic                          stop_ok;

	always_ff @(posedge clk) begin
		if (shift_en) begin
			byte_q <= byte_in;
		end
	end

	// a byte beyond the delimiter length is not compared
	assign start_ok = (start_len <= CELL_IDX) || (byte_q == start_byte);
	assign stop_ok  = (stop_len <= CELL_IDX) || (byte_q == stop_byte);

	assign byte_out          = byte_q;
	assign hit_out.start_hit = hit_in.start_hit & start_ok;
	assign hit_out.stop_hit  = hit_in.stop_hit & stop_ok;

endmodule

>>> hw/rtl/dpf_judge.sv
// dpf_judge: position counter, open packet state and the result register
// depends on dpf_pkg
module dpf_judge #(
	parameter int MAX_DELIM     = dpf_pkg::MAX_DELIM_DEF,
	parameter int POSITION_BITS = dpf_pkg::POSITION_BITS_DEF
) (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         judge_req,
	input  dpf_pkg::dpf_hit_t            hits,
	input  logic [dpf_pkg::LEN_BITS-1:0] stop_len,
	output logic                         judge_fire,
	output logic                         out_valid,
	input  logic                         out_ready,
	output logic [dpf_pkg::OUT_BITS-1:0] packet_begin,
	output logic [dpf_pkg::OUT_BITS-1:0] packet_length
);

	localparam logic [dpf_pkg::LEN_BITS-1:0] MAX_LEN = MAX_DELIM[dpf_pkg::LEN_BITS-1:0];

	logic [POSITION_BITS-1:0]     pos_q;
	logic [POSITION_BITS-1:0]     begin_q;
	logic                         open_q;
	logic                         out_valid_q;
	logic [dpf_pkg::OUT_BITS-1:0] begin_out_q;
	logic [dpf_pkg::OUT_BITS-1:0] length_out_q;
	logic [dpf_pkg::LEN_BITS-1:0] stop_eff;
	logic [POSITION_BITS-1:0]     length_full;
	logic                         emit;

	assign judge_fire  = judge_req && (!out_valid_q || out_ready);
	assign emit        = judge_fire && !hits.start_hit && open_q && hits.stop_hit;
	assign stop_eff    = (stop_len > MAX_LEN) ? MAX_LEN : stop_len;
	assign length_full = pos_q - begin_q + POSITION_BITS'(stop_eff);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pos_q       <= '0;
			begin_q     <= '0;
			open_q      <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (judge_fire) begin
				pos_q <= pos_q + POSITION_BITS'(1);
				// a later start delimiter restarts the packet
				if (hits.start_hit) begin
					begin_q <= pos_q;
					open_q  <= 1'b1;
				end else if (emit) begin
					open_q <= 1'b0;
				end
			end
			if (emit) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (emit) begin
			begin_out_q  <= dpf_pkg::OUT_BITS'(begin_q);
			length_out_q <= dpf_pkg::OUT_BITS'(length_full);
		end
	end

	assign out_valid     = out_valid_q;
	assign packet_begin  = begin_out_q;
	assign packet_length = length_out_q;

endmodule
